/* hw/rtl/hcrp_pkg.sv */
// hcrp_pkg: shared types and codes for the haptic clip repeat player
// item structs, mode codes and configuration register indexes
// no dependencies
package hcrp_pkg;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [2:0] CFG_GAIN          = 3'd0;
    localparam logic [2:0] CFG_REPEAT_COUNT  = 3'd1;
    localparam logic [2:0] CFG_GAP_FRAMES    = 3'd2;
    localparam logic [2:0] CFG_LEAD_GAP      = 3'd3;
    localparam logic [2:0] CFG_RATE_STEP     = 3'd4;
    localparam logic [2:0] CFG_CLIP_LENGTH   = 3'd5;
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd6;
    localparam logic [2:0] CFG_GUARD_LIMIT   = 3'd7;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;

    typedef struct packed {
        logic        [1:0]  mode;
        logic        [15:0] load_index;
        logic signed [15:0] load_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] channel_zero;
        logic signed [15:0] channel_one;
        logic signed [15:0] channel_two;
        logic signed [15:0] channel_three;
        logic               finished;
    } t_out_item;

endpackage

/* hw/rtl/haptic_clip_repeat_player.sv */
// haptic_clip_repeat_player: clip store, playback sequencer and frame output pipeline
// depends on hcrp_pkg
//
// channel   signals                                   beat taken when
// -------   ---------------------------------------   ---------------------------
// item in   start, busy, i_item                       start && !busy
// result    o_strobe, o_result                        o_strobe (one cycle, no stall)
// config    i_cfg_valid, o_cfg_ready, i_cfg_index,    i_cfg_valid && o_cfg_ready
//           i_cfg_data
//
// load and start beats can follow each other every cycle while busy is low.
// a tick beat raises busy for one cycle, so no tick is taken while busy is high;
// the sequencer state is updated in the accept cycle and the clip memory read issued.
// the frame appears on o_result after the memory read, gain multiply, magnitude
// and scale registers; the receiver cannot stall it.
// synchronous active-low reset sets the sequencer and config to their reset values; busy is high in reset.
// the clip memory is not cleared and has no reset.
module haptic_clip_repeat_player #(
    parameter int CLIP_DEPTH   = 65536,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  hcrp_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output hcrp_pkg::t_out_item o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);

    localparam int          AW      = $clog2(CLIP_DEPTH);
    localparam int          IW      = (AW > 17) ? AW : 17;
    localparam logic [31:0] DEPTH_W = 32'(CLIP_DEPTH);
    localparam logic [3:0]  MAXCH   = 4'(MAX_CHANNELS);

    // configuration
    logic [15:0] r_gain;
    logic [7:0]  r_repeat;
    logic [23:0] r_gap_frames;
    logic [23:0] r_lead_gap;
    logic [23:0] r_rate_step;
    logic [16:0] r_clip_len;
    logic [2:0]  r_chan_cnt;
    logic [23:0] r_guard_limit;

    // sequencer
    logic [32:0] r_pos, n_pos;
    logic [23:0] r_gap_cnt, n_gap_cnt;
    logic [7:0]  r_passes, n_passes;
    logic        r_in_gap, n_in_gap;
    logic        r_ended, n_ended;
    logic [23:0] r_guard_cnt, n_guard_cnt;
    logic        r_busy;

    logic        load_acc, start_acc, tick_acc;
    logic        load_ok;
    logic [IW-1:0] wr_ext, rd_ext;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [16:0] idx, len;
    logic        end0, play;

    logic signed [15:0] mem [CLIP_DEPTH];

    // frame pipeline
    logic               r_s1_vld, r_s1_play, r_s1_fin;
    logic signed [15:0] r_rd_data;
    logic               r_s2_vld, r_s2_play, r_s2_fin;
    logic signed [32:0] r_prod;
    logic               r_s3_vld, r_s3_play, r_s3_fin, r_neg;
    logic [30:0]        r_mag;

    logic [32:0]        prod_abs;
    logic               sat;
    logic [37:0]        mul_k;
    logic [15:0]        mag16;
    logic signed [15:0] v;
    logic [3:0]         ch, hap_l, hap_r;
    logic signed [15:0] chan [4];
    hcrp_pkg::t_out_item n_result;

    assign load_acc  = start && !busy && (i_item.mode == hcrp_pkg::MODE_LOAD);
    assign start_acc = start && !busy && (i_item.mode == hcrp_pkg::MODE_START);
    assign tick_acc  = start && !busy && (i_item.mode == hcrp_pkg::MODE_TICK);
    assign busy        = r_busy | ~i_rst_n;
    assign o_cfg_ready = 1'b1;

    assign load_ok = {16'b0, i_item.load_index} < DEPTH_W;
    assign wr_ext  = IW'(i_item.load_index);
    assign wr_addr = wr_ext[AW-1:0];
    assign idx     = r_pos[32:16];
    assign rd_ext  = IW'(idx);
    assign rd_addr = rd_ext[AW-1:0];
    assign len     = ({15'b0, r_clip_len} > DEPTH_W) ? DEPTH_W[16:0] : r_clip_len;

    always_comb begin
        n_pos       = r_pos;
        n_gap_cnt   = r_gap_cnt;
        n_passes    = r_passes;
        n_in_gap    = r_in_gap;
        n_ended     = r_ended;
        n_guard_cnt = r_guard_cnt;
        end0        = r_ended || (r_guard_cnt >= r_guard_limit);
        play        = 1'b0;
        if (start_acc) begin
            n_pos       = '0;
            n_gap_cnt   = r_lead_gap;
            n_passes    = '0;
            n_in_gap    = 1'b1;
            n_ended     = 1'b0;
            n_guard_cnt = '0;
        end else if (tick_acc) begin
            n_ended = end0;
            if (!end0) begin
                if (r_in_gap) begin
                    if (r_gap_cnt <= 24'd1) begin
                        n_gap_cnt = '0;
                        if (r_passes >= r_repeat) begin
                            n_ended = 1'b1;
                        end else begin
                            n_in_gap = 1'b0;
                            n_pos    = '0;
                        end
                    end else begin
                        n_gap_cnt = r_gap_cnt - 24'd1;
                    end
                end else if (idx >= len) begin
                    // pass end: silent frame, then the gap
                    n_in_gap  = 1'b1;
                    n_gap_cnt = r_gap_frames;
                    if (r_passes != 8'hFF) begin
                        n_passes = r_passes + 8'd1;
                    end
                end else begin
                    play  = 1'b1;
                    n_pos = r_pos + {9'b0, r_rate_step};
                end
                n_guard_cnt = r_guard_cnt + 24'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain        <= 16'd256;
            r_repeat      <= 8'd5;
            r_gap_frames  <= 24'd28800;
            r_lead_gap    <= 24'd14400;
            r_rate_step   <= 24'd65536;
            r_clip_len    <= 17'd0;
            r_chan_cnt    <= 3'd4;
            r_guard_limit <= 24'd2880000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hcrp_pkg::CFG_GAIN:          r_gain        <= i_cfg_data[15:0];
                hcrp_pkg::CFG_REPEAT_COUNT:  r_repeat      <= i_cfg_data[7:0];
                hcrp_pkg::CFG_GAP_FRAMES:    r_gap_frames  <= i_cfg_data;
                hcrp_pkg::CFG_LEAD_GAP:      r_lead_gap    <= i_cfg_data;
                hcrp_pkg::CFG_RATE_STEP:     r_rate_step   <= i_cfg_data;
                hcrp_pkg::CFG_CLIP_LENGTH:   r_clip_len    <= i_cfg_data[16:0];
                hcrp_pkg::CFG_CHANNEL_COUNT: r_chan_cnt    <= i_cfg_data[2:0];
                hcrp_pkg::CFG_GUARD_LIMIT:   r_guard_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_gap_cnt   <= '0;
            r_passes    <= '0;
            r_in_gap    <= 1'b1;
            r_ended     <= 1'b1;
            r_guard_cnt <= '0;
            r_busy      <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_gap_cnt   <= n_gap_cnt;
            r_passes    <= n_passes;
            r_in_gap    <= n_in_gap;
            r_ended     <= n_ended;
            r_guard_cnt <= n_guard_cnt;
            r_busy      <= tick_acc;
        end
    end

    // clip memory: one write port for loads, one registered read for ticks
    always_ff @(posedge i_clk) begin
        if (load_acc && load_ok) begin
            mem[wr_addr] <= i_item.load_sample;
        end
        if (tick_acc) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_s1_vld <= tick_acc;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            o_strobe <= r_s3_vld;
        end
    end

    assign prod_abs = r_prod[32] ? 33'(-r_prod) : r_prod;

    always_ff @(posedge i_clk) begin
        r_s1_play <= play;
        r_s1_fin  <= n_ended;
        r_s2_play <= r_s1_play;
        r_s2_fin  <= r_s1_fin;
        r_prod    <= $signed({{17{r_rd_data[15]}}, r_rd_data}) * $signed({17'b0, r_gain});
        r_s3_play <= r_s2_play;
        r_s3_fin  <= r_s2_fin;
        r_neg     <= r_prod[32];
        r_mag     <= prod_abs[30:0];
        o_result  <= n_result;
    end

    // clamp to one, then times 32767 truncated: (m << 15) - m, top bits
    assign sat   = |r_mag[30:23];
    assign mul_k = {r_mag[22:0], 15'b0} - {15'b0, r_mag[22:0]};
    assign mag16 = sat ? hcrp_pkg::SAMPLE_MAX : {1'b0, mul_k[37:23]};
    assign v     = r_neg ? -$signed(mag16) : $signed(mag16);

    always_comb begin
        ch = (r_chan_cnt == 3'd0) ? 4'd1 : {1'b0, r_chan_cnt};
        if (ch > MAXCH) begin
            ch = MAXCH;
        end
        hap_l = (ch >= 4'd4) ? 4'd2 : 4'd0;
        hap_r = (ch >= 4'd4) ? 4'd3 : ch - 4'd1;
        for (int c = 0; c < 4; c++) begin
            chan[c] = (r_s3_play && (4'(c) < ch) && (4'(c) == hap_l || 4'(c) == hap_r))
                      ? v : 16'sd0;
        end
        n_result.channel_zero  = chan[0];
        n_result.channel_one   = chan[1];
        n_result.channel_two   = chan[2];
        n_result.channel_three = chan[3];
        n_result.finished      = r_s3_fin;
    end

endmodule

/* hw/rtl/hcrp_checker.sv */
// hcrp_checker: port-level assertions for the haptic clip repeat player
// depends on hcrp_pkg; bound to haptic_clip_repeat_player below
module hcrp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                i_busy,
    input hcrp_pkg::t_in_item  i_item,
    input logic                i_strobe,
    input hcrp_pkg::t_out_item i_result
);

    logic tick_beat;
    assign tick_beat = i_start && !i_busy && (i_item.mode == hcrp_pkg::MODE_TICK);

    // every tick beat gives exactly one frame
    a_frame_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe == $past(tick_beat, 4))
        else $error("frame strobe does not match tick beat");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_beat |=> i_busy)
        else $error("busy not raised after tick beat");

    a_finished_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && i_result.finished) |->
        (i_result.channel_zero == 16'sd0 && i_result.channel_one == 16'sd0 &&
         i_result.channel_two == 16'sd0 && i_result.channel_three == 16'sd0))
        else $error("finished frame carries samples");

    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe |-> (i_result.channel_zero != 16'sh8000 &&
                      i_result.channel_three != 16'sh8000))
        else $error("sample outside symmetric range");

endmodule

bind haptic_clip_repeat_player hcrp_checker u_hcrp_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_item   (i_item),
    .i_strobe (o_strobe),
    .i_result (o_result)
);
